// ----- rtl/text_mode_console_writer_defines.svh -----
// Assertion macros for the text-mode console writer checker.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define TMCW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define TMCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tmcw_pkg.sv -----
// Shared types and constants for the text-mode console writer.
// No dependencies; used by the interfaces, the RAM user and the checker.
`default_nettype none

package tmcw_pkg;

  // Item field widths
  localparam int OP_W      = 2;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int IDX_IN_W  = 11;
  localparam int CUR_OUT_W = 11;
  localparam int CELL_W    = 16;
  localparam int SCREEN_W  = 2;

  // Default geometry
  localparam int COLUMNS_DEF      = 80;
  localparam int ROWS_DEF         = 25;
  localparam int SCREEN_COUNT_DEF = 4;

  // Cell and character constants
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam int                TAB_SPACES = 4;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_BKSP  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

endpackage

`default_nettype wire

// ----- rtl/tmcw_if.sv -----
// Valid/ready channel interfaces for the console writer: input, result, config.
// Depends on tmcw_pkg for field widths.
`default_nettype none

interface tmcw_in_if;
  import tmcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [CHAR_W-1:0]   char_code;
  logic [COLOR_W-1:0]  color;
  logic [IDX_IN_W-1:0] cell_index;

  modport source (output valid, output op, output char_code, output color,
                  output cell_index, input ready);
  modport sink   (input valid, input op, input char_code, input color,
                  input cell_index, output ready);
  modport mon    (input valid, input ready, input op, input char_code,
                  input color, input cell_index);
endinterface

interface tmcw_out_if;
  import tmcw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CUR_OUT_W-1:0] cursor_position;
  logic [CELL_W-1:0]    cell_value;

  modport source (output valid, output cursor_position, output cell_value,
                  input ready);
  modport sink   (input valid, input cursor_position, input cell_value,
                  output ready);
  modport mon    (input valid, input ready, input cursor_position,
                  input cell_value);
endinterface

interface tmcw_cfg_if;
  import tmcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [SCREEN_W-1:0] active_screen;

  modport source (output valid, output active_screen, input ready);
  modport sink   (input valid, input active_screen, output ready);
  modport mon    (input valid, input ready, input active_screen);
endinterface

`default_nettype wire

// ----- rtl/tmcw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/text_mode_console_writer.sv -----
// Text-mode console writer: SCREEN_COUNT screens of COLUMNS x ROWS cells in one RAM.
// A scroll or a clear walks the whole screen, a backspace the cells from the cursor on (one
//   RAM port pair, one cell moved per cycle). One item at a time; in ready only when idle.
// Reset: synchronous active-low; then a clearing pass over all SCREEN_COUNT*CELLS cells
//   (8000 by default) fills the RAM with blanks before the first item is taken.
`default_nettype none

module text_mode_console_writer
  import tmcw_pkg::*;
#(
  parameter int COLUMNS      = COLUMNS_DEF,
  parameter int ROWS         = ROWS_DEF,
  parameter int SCREEN_COUNT = SCREEN_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tmcw_cfg_if.sink    cfg_chan,
  tmcw_in_if.sink     in_chan,
  tmcw_out_if.source  out_chan
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int DEPTH  = CELLS * SCREEN_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(CELLS + 1);    // cursor / walk index, holds CELLS
  localparam int SRC_W  = IDX_W + 1;            // walk source, below 2*CELLS
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int SCR_W  = (SCREEN_COUNT > 1) ? $clog2(SCREEN_COUNT) : 1;
  localparam int REP_W  = $clog2(TAB_SPACES);

  // One-hot sequencer states
  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,   // clearing pass after reset
    S_IDLE = 7'b0000010,
    S_EXEC = 7'b0000100,   // decode the op with the screen's cursor loaded
    S_PUT  = 7'b0001000,   // write one character cell
    S_WALK = 7'b0010000,   // shift / blank walk over the screen
    S_READ = 7'b0100000,   // RAM read data returns
    S_DONE = 7'b1000000    // hand result to output register
  } state_t;

  state_t state_r, state_nxt;

  // Config
  logic [SCREEN_W-1:0] active_r;

  // Clearing pass
  logic [ADDR_W-1:0] init_addr_r, init_addr_nxt;

  // Latched item
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [CHAR_W-1:0]   ch_r, ch_nxt;
  logic [COLOR_W-1:0]  color_r, color_nxt;
  logic [IDX_IN_W-1:0] idx_r, idx_nxt;

  // Working context of the selected screen
  logic [SCR_W-1:0]  scr_r, scr_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [REP_W-1:0]  rep_r, rep_nxt;
  logic              more_r, more_nxt;     // return to S_PUT after a scroll
  logic [CELL_W-1:0] val_r, val_nxt;

  // Walk unit: issue read of dst+K, write dst in the next cycle
  logic [IDX_W-1:0] wk_idx_r, wk_idx_nxt;
  logic             wk_row_r, wk_row_nxt;   // K = COLUMNS, else K = 1
  logic             wk_fill_r, wk_fill_nxt; // blank every cell
  logic             wv_r, wv_nxt;
  logic [IDX_W-1:0] wdst_r, wdst_nxt;
  logic             wblank_r, wblank_nxt;

  // Per-screen cursors and column counters
  logic [IDX_W-1:0] cur_arr_r [SCREEN_COUNT];
  logic [COL_W-1:0] col_arr_r [SCREEN_COUNT];
  logic             commit;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [CUR_OUT_W-1:0] out_cur_r, out_cur_nxt;
  logic [CELL_W-1:0]    out_val_r, out_val_nxt;

  // RAM ports
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic [SCR_W-1:0] scr_sel;
  logic             in_fire;

  tmcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_fire        = in_chan.valid && (state_r == S_IDLE);

  assign out_chan.valid           = out_valid_r;
  assign out_chan.cursor_position = out_cur_r;
  assign out_chan.cell_value      = out_val_r;

  // Out-of-range screen numbers saturate to the last screen
  always_comb begin
    if (32'(active_r) >= SCREEN_COUNT) begin
      scr_sel = SCR_W'(SCREEN_COUNT - 1);
    end else begin
      scr_sel = SCR_W'(active_r);
    end
  end

  always_comb begin
    logic [SRC_W-1:0] src;
    logic             issue;
    logic             blank;
    logic [IDX_W-1:0] nl;
    logic             more;

    state_nxt     = state_r;
    init_addr_nxt = init_addr_r;
    op_nxt        = op_r;
    ch_nxt        = ch_r;
    color_nxt     = color_r;
    idx_nxt       = idx_r;
    scr_nxt       = scr_r;
    base_nxt      = base_r;
    cur_nxt       = cur_r;
    col_nxt       = col_r;
    rep_nxt       = rep_r;
    more_nxt      = more_r;
    val_nxt       = val_r;
    wk_idx_nxt    = wk_idx_r;
    wk_row_nxt    = wk_row_r;
    wk_fill_nxt   = wk_fill_r;
    wv_nxt        = 1'b0;
    wdst_nxt      = wdst_r;
    wblank_nxt    = wblank_r;
    out_cur_nxt   = out_cur_r;
    out_val_nxt   = out_val_r;
    commit        = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = init_addr_r;
    ram_wdata = BLANK_CELL;
    ram_re    = 1'b0;
    ram_raddr = base_r;

    src   = SRC_W'(wk_idx_r) + (wk_row_r ? SRC_W'(COLUMNS) : SRC_W'(1));
    issue = (32'(wk_idx_r) < CELLS);
    blank = wk_fill_r || (32'(src) >= CELLS);
    nl    = cur_r - IDX_W'(col_r) + IDX_W'(COLUMNS);
    more  = (rep_r != '0);

    out_valid_nxt = out_valid_r && !out_chan.ready;

    unique case (state_r)
      S_INIT: begin
        ram_we        = 1'b1;
        init_addr_nxt = init_addr_r + 1'b1;
        if (init_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_chan.op;
          ch_nxt    = in_chan.char_code;
          color_nxt = in_chan.color;
          idx_nxt   = in_chan.cell_index;
          scr_nxt   = scr_sel;
          base_nxt  = ADDR_W'(32'(scr_sel) * CELLS);
          cur_nxt   = cur_arr_r[scr_sel];
          col_nxt   = col_arr_r[scr_sel];
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        more_nxt = 1'b0;
        val_nxt  = '0;
        case (op_r)
          OP_PUT: begin
            if (ch_r == CH_NEWLINE) begin
              col_nxt = '0;
              if (32'(nl) >= CELLS) begin
                // newline off the bottom: scroll
                cur_nxt     = IDX_W'(CELLS - COLUMNS);
                wk_idx_nxt  = '0;
                wk_row_nxt  = 1'b1;
                wk_fill_nxt = 1'b0;
                state_nxt   = S_WALK;
              end else begin
                cur_nxt   = nl;
                state_nxt = S_DONE;
              end
            end else if (ch_r == CH_TAB) begin
              ch_nxt    = CH_SPACE;
              rep_nxt   = REP_W'(TAB_SPACES - 1);
              state_nxt = S_PUT;
            end else begin
              rep_nxt   = '0;
              state_nxt = S_PUT;
            end
          end
          OP_BKSP: begin
            if (cur_r != '0) begin
              cur_nxt     = cur_r - IDX_W'(1);
              col_nxt     = (col_r == '0) ? COL_W'(COLUMNS - 1) : col_r - 1'b1;
              wk_idx_nxt  = cur_r - IDX_W'(1);
              wk_row_nxt  = 1'b0;
              wk_fill_nxt = 1'b0;
              state_nxt   = S_WALK;
            end else begin
              state_nxt = S_DONE;
            end
          end
          OP_CLEAR: begin
            cur_nxt     = '0;
            col_nxt     = '0;
            wk_idx_nxt  = '0;
            wk_row_nxt  = 1'b0;
            wk_fill_nxt = 1'b1;
            state_nxt   = S_WALK;
          end
          default: begin  // OP_READ
            if (32'(idx_r) < CELLS) begin
              ram_re    = 1'b1;
              ram_raddr = base_r + ADDR_W'(idx_r);
              state_nxt = S_READ;
            end else begin
              state_nxt = S_DONE;
            end
          end
        endcase
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = base_r + ADDR_W'(cur_r);
        ram_wdata = {color_r, ch_r};
        if (more) begin
          rep_nxt = rep_r - 1'b1;
        end
        if (32'(cur_r) + 32'd1 >= CELLS) begin
          // past the last cell: scroll, then finish any tab spaces left
          cur_nxt     = IDX_W'(CELLS - COLUMNS);
          col_nxt     = '0;
          more_nxt    = more;
          wk_idx_nxt  = '0;
          wk_row_nxt  = 1'b1;
          wk_fill_nxt = 1'b0;
          state_nxt   = S_WALK;
        end else begin
          cur_nxt   = cur_r + IDX_W'(1);
          col_nxt   = (col_r == COL_W'(COLUMNS - 1)) ? '0 : col_r + 1'b1;
          state_nxt = more ? S_PUT : S_DONE;
        end
      end

      S_WALK: begin
        // dst only ever moves below src, so reads see unshifted cells
        if (issue) begin
          ram_re     = !blank;
          ram_raddr  = base_r + ADDR_W'(src);
          wv_nxt     = 1'b1;
          wdst_nxt   = wk_idx_r;
          wblank_nxt = blank;
          wk_idx_nxt = wk_idx_r + IDX_W'(1);
        end
        if (wv_r) begin
          ram_we    = 1'b1;
          ram_waddr = base_r + ADDR_W'(wdst_r);
          ram_wdata = wblank_r ? BLANK_CELL : ram_rdata;
        end
        if (!issue && !wv_r) begin
          state_nxt = more_r ? S_PUT : S_DONE;
        end
      end

      S_READ: begin
        val_nxt   = ram_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_cur_nxt   = CUR_OUT_W'(cur_r);
          out_val_nxt   = val_r;
          commit        = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_addr_r <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      wv_r        <= 1'b0;
      for (int i = 0; i < SCREEN_COUNT; i++) begin
        cur_arr_r[i] <= '0;
        col_arr_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      init_addr_r <= init_addr_nxt;
      out_valid_r <= out_valid_nxt;
      wv_r        <= wv_nxt;
      if (cfg_chan.valid) begin
        active_r <= cfg_chan.active_screen;
      end
      if (commit) begin
        cur_arr_r[scr_r] <= cur_r;
        col_arr_r[scr_r] <= col_r;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    ch_r      <= ch_nxt;
    color_r   <= color_nxt;
    idx_r     <= idx_nxt;
    scr_r     <= scr_nxt;
    base_r    <= base_nxt;
    cur_r     <= cur_nxt;
    col_r     <= col_nxt;
    rep_r     <= rep_nxt;
    more_r    <= more_nxt;
    val_r     <= val_nxt;
    wk_idx_r  <= wk_idx_nxt;
    wk_row_r  <= wk_row_nxt;
    wk_fill_r <= wk_fill_nxt;
    wdst_r    <= wdst_nxt;
    wblank_r  <= wblank_nxt;
    out_cur_r <= out_cur_nxt;
    out_val_r <= out_val_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/tmcw_checker.sv -----
// Port-level checker for the console writer, bound to the top level.
// Depends on tmcw_pkg and the assertion macros header.
`default_nettype none
`include "text_mode_console_writer_defines.svh"

module tmcw_checker
  import tmcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CUR_OUT_W-1:0] out_cursor_position
);

  localparam int CELLS = COLUMNS * ROWS;

  `TMCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `TMCW_ASSERT_SAME(a_cur_range, out_valid, 32'(out_cursor_position) < CELLS, "cursor range")
  `TMCW_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while busy")
  `TMCW_ASSERT_SAME(a_post_idle, $rose(out_valid), in_ready, "result posted while busy")

endmodule

bind text_mode_console_writer tmcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tmcw_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_chan.valid),
  .in_ready            (in_chan.ready),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_cursor_position (out_chan.cursor_position)
);

`default_nettype wire

// ----- sim/tb_text_mode_console_writer.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for text_mode_console_writer: directed cases, then randomized
// put/newline/tab/backspace/clear/read traffic with random idling on both channels.
// Depends on tmcw_pkg and the channel interfaces in rtl/tmcw_if.sv.

module tb_text_mode_console_writer;
  import tmcw_pkg::*;

  // Default geometry of the instance under test
  localparam int COLS    = COLUMNS_DEF;
  localparam int LINES   = ROWS_DEF;
  localparam int CELLS   = COLS * LINES;
  localparam int SCREENS = SCREEN_COUNT_DEF;

  // Longest legal silence is the post-reset clearing pass over SCREENS*CELLS cells;
  // a scroll, shift or clear walks one screen, plus stalls and gaps.
  localparam int SILENCE_LIMIT = 5 * SCREENS * CELLS;

  localparam int RANDOM_ITEMS = 150;

  typedef struct packed {
    logic [CUR_OUT_W-1:0] cursor_position;
    logic [CELL_W-1:0]    cell_value;
  } console_result_t;

  logic clk;
  logic rst_n;

  tmcw_cfg_if cfg_bus ();
  tmcw_in_if  in_bus ();
  tmcw_out_if out_bus ();

  text_mode_console_writer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_bus),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the console: cell stores, per-screen cursors, selected screen
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0]   screen_cells [SCREENS][CELLS];
  int unsigned         screen_cursor [SCREENS];
  logic [SCREEN_W-1:0] shadow_screen;

  console_result_t pending_results [$];
  int              mismatch_count;
  int unsigned     items_sent;
  int unsigned     silent_cycles;

  // Random idling controls; set to run a stretch with no gaps and no stalls
  bit idle_free;
  bit stall_free;

  // Register values past the screen count fall back to the last screen
  function automatic int unsigned selected_screen();
    int unsigned s;
    s = 32'(shadow_screen);
    if (s >= SCREENS) s = SCREENS - 1;
    return s;
  endfunction

  // Cursor ran off the end: rows move up, last row goes blank
  function automatic void scroll_if_full(input int unsigned s);
    if (screen_cursor[s] >= CELLS) begin
      for (int i = 0; i < CELLS - COLS; i++) screen_cells[s][i] = screen_cells[s][i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen_cells[s][i] = BLANK_CELL;
      screen_cursor[s] = CELLS - COLS;
    end
  endfunction

  function automatic void store_char(input int unsigned s, input logic [CHAR_W-1:0] ch,
                                     input logic [COLOR_W-1:0] color);
    if (screen_cursor[s] < CELLS) screen_cells[s][screen_cursor[s]] = {color, ch};
    screen_cursor[s]++;
    scroll_if_full(s);
  endfunction

  // Apply one accepted item to the shadow and return what the block must answer
  function automatic console_result_t console_apply(input op_t op,
                                                    input logic [CHAR_W-1:0] ch,
                                                    input logic [COLOR_W-1:0] color,
                                                    input logic [IDX_IN_W-1:0] idx);
    int unsigned     s;
    console_result_t r;
    s = selected_screen();
    r.cell_value = '0;
    case (op)
      OP_PUT: begin
        if (ch == CH_NEWLINE) begin
          screen_cursor[s] = (screen_cursor[s] / COLS + 1) * COLS;
          scroll_if_full(s);
        end else if (ch == CH_TAB) begin
          // end-of-screen check after every space, so a tab can scroll midway
          repeat (TAB_SPACES) store_char(s, CH_SPACE, color);
        end else begin
          store_char(s, ch, color);
        end
      end
      OP_BKSP: begin
        // no effect at cell zero
        if (screen_cursor[s] > 0 && screen_cursor[s] <= CELLS) begin
          screen_cursor[s]--;
          for (int i = screen_cursor[s]; i + 1 < CELLS; i++)
            screen_cells[s][i] = screen_cells[s][i + 1];
          screen_cells[s][CELLS - 1] = BLANK_CELL;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_cells[s][i] = BLANK_CELL;
        screen_cursor[s] = 0;
      end
      default: begin
        // reads past the screen answer zero
        if (idx < CELLS) r.cell_value = screen_cells[s][idx];
      end
    endcase
    r.cursor_position = screen_cursor[s][CUR_OUT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Counts cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      silent_cycles <= 0;
    end else if (silent_cycles + 1 >= SILENCE_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles, %0d results outstanding",
               $time, SILENCE_LIMIT, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      silent_cycles <= silent_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check and prediction, one process so queue order never races.
  // Results are checked before the item of the same edge is predicted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_and_predict
    console_result_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: cursor %0d cell 0x%04h", $time,
                   out_bus.cursor_position, out_bus.cell_value);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_bus.cursor_position !== want.cursor_position) begin
            $display("%0t cursor_position mismatch: expected %0d actual %0d", $time,
                     want.cursor_position, out_bus.cursor_position);
            mismatch_count++;
          end
          if (out_bus.cell_value !== want.cell_value) begin
            $display("%0t cell_value mismatch: expected 0x%04h actual 0x%04h", $time,
                     want.cell_value, out_bus.cell_value);
            mismatch_count++;
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) shadow_screen = cfg_bus.active_screen;
      if (in_bus.valid && in_bus.ready)
        pending_results.push_back(console_apply(op_t'(in_bus.op), in_bus.char_code,
                                                in_bus.color, in_bus.cell_index));
    end
  end

  // ---------------------------------------------------------------------------
  // Result-side backpressure: ready held high for a while, then a stall,
  // mostly short, now and then long
  // ---------------------------------------------------------------------------
  initial begin : result_stalls
    int unsigned hold;
    int unsigned stall;
    out_bus.ready <= 1'b1;
    forever begin
      hold = $urandom_range(1, 24);
      repeat (hold) @(posedge clk);
      if (!stall_free) begin
        stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(15, 60);
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (idle_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_byte();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [IDX_IN_W-1:0] rand_idx();
    return IDX_IN_W'($urandom);
  endfunction

  // Sends one item; valid stays high on return so a back-to-back item needs no gap
  task automatic send_item(input op_t op, input logic [CHAR_W-1:0] ch,
                           input logic [COLOR_W-1:0] color, input logic [IDX_IN_W-1:0] idx);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.op         <= op;
    in_bus.char_code  <= ch;
    in_bus.color      <= color;
    in_bus.cell_index <= idx;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
  endtask

  // Sender holds off until every outstanding result is back
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Register write, only with the block idle
  task automatic set_screen(input logic [SCREEN_W-1:0] value);
    drain_results();
    cfg_bus.valid         <= 1'b1;
    cfg_bus.active_screen <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic read_cell(input logic [IDX_IN_W-1:0] idx);
    send_item(OP_READ, rand_byte(), rand_byte(), idx);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh screen: blanks everywhere, out-of-range reads give zero
  task automatic test_reset_contents();
    read_cell(0);
    read_cell(IDX_IN_W'(CELLS - 1));
    read_cell(IDX_IN_W'(CELLS));
    read_cell({IDX_IN_W{1'b1}});
  endtask

  // Character and color extremes land in the right bytes
  task automatic test_put_extremes();
    send_item(OP_PUT, 8'h00, 8'h00, '0);
    send_item(OP_PUT, 8'hFF, 8'hFF, '1);
    send_item(OP_PUT, 8'h41, 8'h5A, '0);
    read_cell(0);
    read_cell(1);
    read_cell(2);
  endtask

  // Tab writes four colored spaces, newline jumps to the next row
  task automatic test_control_chars();
    send_item(OP_PUT, CH_TAB, 8'h1E, '0);
    send_item(OP_PUT, CH_NEWLINE, 8'hC3, '0);
    send_item(OP_PUT, CH_NEWLINE, 8'h00, '0);
    read_cell(3);
    read_cell(6);
    read_cell(7);
  endtask

  // Backspace shifts the screen left; clear resets; backspace at cell zero is a no-op
  task automatic test_backspace_and_clear();
    send_item(OP_PUT, 8'h58, 8'h71, '0);
    send_item(OP_BKSP, 8'h00, 8'h00, '0);
    read_cell(IDX_IN_W'(2 * COLS));
    send_item(OP_CLEAR, 8'hFF, 8'hFF, '1);
    send_item(OP_BKSP, 8'hFF, 8'hFF, '1);
  endtask

  // Screens keep separate stores and cursors
  task automatic test_screen_select();
    set_screen(3);
    send_item(OP_PUT, 8'h5A, 8'h0F, '0);
    read_cell(0);
    set_screen(1);
    read_cell(0);
    set_screen(0);
  endtask

  // Bring the cursor to the last row and tab across the end of the screen,
  // so the scroll lands inside or after the four spaces
  task automatic test_tab_scroll();
    int unsigned row;
    int unsigned lines_down;
    int unsigned spill;
    set_screen(2);
    for (int rep = 0; rep < 4; rep++) begin
      drain_results();
      row        = screen_cursor[selected_screen()] / COLS;
      lines_down = (row == LINES - 1) ? 1 : LINES - 1 - row;
      repeat (lines_down)
        send_item(OP_PUT, CH_NEWLINE, rand_byte(), rand_idx());
      // cursor now at the start of the last row; walk to COLS-4+rep
      spill = COLS - 4 + rep;
      repeat (spill / TAB_SPACES) send_item(OP_PUT, CH_TAB, rand_byte(), rand_idx());
      repeat (spill % TAB_SPACES)
        send_item(OP_PUT, CHAR_W'($urandom_range(32, 126)), rand_byte(), rand_idx());
      send_item(OP_PUT, CH_TAB, rand_byte(), rand_idx());
      read_cell(IDX_IN_W'(CELLS - COLS - 1));
      read_cell(IDX_IN_W'(CELLS - COLS));
      read_cell(IDX_IN_W'(CELLS - COLS + 3));
    end
  endtask

  // Mostly text, newlines and tabs with random content; reads, backspaces,
  // clears, screen switches and raw noise mixed in
  task automatic test_random_traffic(input int unsigned count);
    int unsigned start;
    int unsigned kind;
    int unsigned len;
    int unsigned r;
    start = items_sent;
    while (items_sent - start < count) begin
      kind       = $urandom_range(0, 99);
      idle_free  = ($urandom_range(0, 99) < 15);
      stall_free = idle_free;
      len        = $urandom_range(1, 6);
      if (kind < 38) begin
        repeat ($urandom_range(1, 30))
          send_item(OP_PUT, rand_byte(), rand_byte(), rand_idx());
      end else if (kind < 53) begin
        repeat ($urandom_range(1, 25))
          send_item(OP_PUT, CH_NEWLINE, rand_byte(), rand_idx());
      end else if (kind < 62) begin
        repeat ($urandom_range(1, 12))
          send_item(OP_PUT, CH_TAB, rand_byte(), rand_idx());
      end else if (kind < 77) begin
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 15)      read_cell(IDX_IN_W'($urandom_range(CELLS, 2 ** IDX_IN_W - 1)));
          else if (r < 55) read_cell(IDX_IN_W'($urandom_range(0, 2 * COLS - 1)));
          else             read_cell(IDX_IN_W'($urandom_range(0, CELLS - 1)));
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 4))
          send_item(OP_BKSP, rand_byte(), rand_byte(), rand_idx());
      end else if (kind < 89) begin
        send_item(OP_CLEAR, rand_byte(), rand_byte(), rand_idx());
      end else if (kind < 94) begin
        send_item(op_t'($urandom_range(0, 3)), rand_byte(), rand_byte(), rand_idx());
      end else if (kind < 97) begin
        set_screen(SCREEN_W'($urandom_range(0, SCREENS - 1)));
      end else begin
        drain_results();
      end
    end
    idle_free  = 1'b0;
    stall_free = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int s = 0; s < SCREENS; s++) begin
      for (int i = 0; i < CELLS; i++) screen_cells[s][i] = BLANK_CELL;
      screen_cursor[s] = 0;
    end
    shadow_screen  = '0;
    mismatch_count = 0;
    items_sent     = 0;
    silent_cycles  = 0;
    idle_free      = 1'b0;
    stall_free     = 1'b0;

    rst_n                 <= 1'b0;
    in_bus.valid          <= 1'b0;
    in_bus.op             <= OP_PUT;
    in_bus.char_code      <= '0;
    in_bus.color          <= '0;
    in_bus.cell_index     <= '0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.active_screen <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // The block runs a clearing pass before taking the first item;
    // the first send simply waits it out on ready.
    test_reset_contents();
    test_put_extremes();
    test_control_chars();
    test_backspace_and_clear();
    test_screen_select();
    test_tab_scroll();
    set_screen(0);
    test_random_traffic(RANDOM_ITEMS);

    // Everything back, then a screen-length quiet period to catch stray results
    drain_results();
    repeat (CELLS + 16) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tmcw_pkg.sv
rtl/tmcw_if.sv
rtl/tmcw_ram.sv
rtl/text_mode_console_writer.sv
rtl/tmcw_checker.sv
sim/tb_text_mode_console_writer.sv
